>>> rtl/sorted_list_union_merge_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list union merge block
// Concurrent checks clocked on a rising edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_UNION_MERGE_TOP_MACROS_SVH
`define SORTED_LIST_UNION_MERGE_TOP_MACROS_SVH
`ifndef SYNTH
`define SLUM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SLUM_NEVER(lbl, clk, rst_n, cond) \
  `SLUM_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define SLUM_ASSERT(lbl, clk, rst_n, prop)
`define SLUM_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/slum_pkg.sv
// ----------------------------------------------------------------------------
// slum_pkg
// Shared types and constants of the sorted list union merge block.
// ----------------------------------------------------------------------------
package slum_pkg;

  localparam int LANES_DEF      = 8;
  localparam int LANE_FIELD_MAX = 8;   // reach of the 3-bit lane field
  localparam int IN_DEPTH       = 2;
  localparam int OUT_DEPTH      = 4;
  localparam logic [3:0] CFG_RESET = 4'd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NEXT  = 2'd1,
    OP_SKIP  = 2'd2,
    OP_REPLY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ADV  = 2'd0,
    KIND_SKIP = 2'd1,
    KIND_CUR  = 2'd2,
    KIND_END  = 2'd3
  } kind_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  lane;
    logic [31:0] docid;
    logic        ended;
    logic [31:0] target;
    logic        in_range;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  lane;
    logic [31:0] docid;
    logic        last;
  } res_t;

  function automatic int lanes_eff(input int lanes);
    return (lanes < LANE_FIELD_MAX) ? lanes : LANE_FIELD_MAX;
  endfunction

endpackage

>>> rtl/slum_fifo.sv
// ----------------------------------------------------------------------------
// slum_fifo
// Small register FIFO, first-word-fall-through read.
// ----------------------------------------------------------------------------
module slum_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         valid_o
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          wr_en, rd_en;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_en ? AW'((wr_q + 1'b1) % DEPTH) : wr_q;
    rd_d  = rd_en ? AW'((rd_q + 1'b1) % DEPTH) : rd_q;
    cnt_d = cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/slum_front.sv
// ----------------------------------------------------------------------------
// slum_front
// Accepts input words, decodes the operation and lane range, queues them.
// ----------------------------------------------------------------------------
module slum_front import slum_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [3:0]  n_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [2:0]  lane_i,
  input  logic [31:0] lane_docid_i,
  input  logic        lane_ended_i,
  input  logic [31:0] target_i,
  input  logic        pop_i,
  output item_t       item_o,
  output logic        valid_o
);

  item_t              item;
  logic [$bits(item_t)-1:0] rdata;

  always_comb begin
    item.op       = op_e'(operation_i);
    item.lane     = lane_i;
    item.docid    = lane_docid_i;
    item.ended    = lane_ended_i;
    item.target   = target_i;
    item.in_range = ({1'b0, lane_i} < n_i);
  end

  slum_fifo #(.W($bits(item_t)), .DEPTH(IN_DEPTH)) u_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(item),
    .full_o (full),
    .pop_i  (pop_i),
    .rdata_o(rdata),
    .valid_o(valid_o)
  );

  assign item_o = item_t'(rdata);

endmodule

>>> rtl/slum_back.sv
// ----------------------------------------------------------------------------
// slum_back
// Executes queued words: lane state, request scan and minimum scan.
// ----------------------------------------------------------------------------
module slum_back import slum_pkg::*; #(
  parameter int LANES = LANES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] n_i,
  input  item_t      item_i,
  input  logic       valid_i,
  output logic       pop_o,
  output logic       push_o,
  output res_t       res_o,
  input  logic       full_i
);

  localparam int NL = lanes_eff(LANES);
  localparam int IW = $clog2(NL);
  localparam int CW = IW + 1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NEXT = 2'd1,
    MODE_SKIP = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_REQ  = 3'b010,
    ST_MIN  = 3'b100
  } st_e;

  logic [31:0]   head_q [NL];
  logic [NL-1:0] live_q, live_d;
  logic [31:0]   cur_q, cur_d, best_q, best_d, tgt_q, tgt_d;
  logic [3:0]    pend_q, pend_d, cnt_q, cnt_d;
  mode_e         mode_q, mode_d;
  st_e           st_q, st_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          found_q, found_d, skip_q, skip_d, hold_v_q, hold_v_d;
  logic [2:0]    hold_q, hold_d;
  logic          hw_en;
  logic [IW-1:0] hw_idx;
  logic [IW-1:0] ri;
  logic [31:0]   rd_head;
  logic          rd_live, at_end, any_live, match;
  logic [NL-1:0] in_use;

  assign ri      = idx_q[IW-1:0];
  assign rd_head = head_q[ri];
  assign rd_live = live_q[ri];
  assign at_end  = (5'(idx_q) == 5'(n_i));
  assign hw_idx  = item_i.lane[IW-1:0];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      in_use[i] = (5'(i) < 5'(n_i));
    end
    any_live = |(live_q & in_use);
    match    = rd_live && (skip_q ? (rd_head < tgt_q) : (rd_head == cur_q));
  end

  always_comb begin
    live_d   = live_q;
    cur_d    = cur_q;
    best_d   = best_q;
    tgt_d    = tgt_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    mode_d   = mode_q;
    st_d     = st_q;
    idx_d    = idx_q;
    found_d  = found_q;
    skip_d   = skip_q;
    hold_v_d = hold_v_q;
    hold_d   = hold_q;
    hw_en    = 1'b0;
    pop_o    = 1'b0;
    push_o   = 1'b0;
    res_o    = '{kind: KIND_CUR, lane: 3'd0, docid: 32'd0, last: 1'b0};
    case (st_q)
      ST_IDLE: begin
        if (valid_i && !full_i) begin
          pop_o = 1'b1;
          case (item_i.op)
            OP_LOAD, OP_REPLY: begin
              if (item_i.in_range && (item_i.op == OP_LOAD || mode_q != MODE_IDLE)) begin
                hw_en          = 1'b1;
                live_d[hw_idx] = !item_i.ended;
                if (item_i.op == OP_REPLY) begin
                  if (pend_q != '0) pend_d = pend_q - 1'b1;
                  if (pend_q <= 4'd1) begin
                    mode_d  = MODE_IDLE;
                    idx_d   = '0;
                    found_d = 1'b0;
                    st_d    = ST_MIN;
                  end
                end
              end
            end
            default: begin
              if (mode_q == MODE_IDLE) begin
                if (item_i.op == OP_SKIP && item_i.target <= cur_q) begin
                  push_o = 1'b1;
                  res_o  = any_live ? res_t'{KIND_CUR, 3'd0, cur_q, 1'b1}
                                    : res_t'{KIND_END, 3'd0, 32'd0, 1'b1};
                end else begin
                  skip_d   = (item_i.op == OP_SKIP);
                  tgt_d    = item_i.target;
                  idx_d    = '0;
                  cnt_d    = '0;
                  hold_v_d = 1'b0;
                  st_d     = ST_REQ;
                end
              end
            end
          endcase
        end
      end
      ST_REQ: begin
        if (!full_i) begin
          // the held request goes out once its successor, or the scan end, is known
          res_o.kind  = skip_q ? KIND_SKIP : KIND_ADV;
          res_o.lane  = hold_q;
          res_o.docid = skip_q ? tgt_q : cur_q;
          if (at_end) begin
            if (hold_v_q) begin
              push_o     = 1'b1;
              res_o.last = 1'b1;
              mode_d     = skip_q ? MODE_SKIP : MODE_NEXT;
              pend_d     = cnt_q;
              st_d       = ST_IDLE;
            end else begin
              idx_d   = '0;
              found_d = 1'b0;
              st_d    = ST_MIN;
            end
          end else begin
            if (match) begin
              push_o   = hold_v_q;
              hold_d   = 3'(ri);
              hold_v_d = 1'b1;
              cnt_d    = cnt_q + 1'b1;
            end
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_MIN: begin
        if (!full_i) begin
          if (at_end) begin
            push_o = 1'b1;
            res_o  = found_q ? res_t'{KIND_CUR, 3'd0, best_q, 1'b1}
                             : res_t'{KIND_END, 3'd0, 32'd0, 1'b1};
            if (found_q) cur_d = best_q;
            st_d = ST_IDLE;
          end else begin
            if (rd_live && (!found_q || rd_head < best_q)) begin
              best_d  = rd_head;
              found_d = 1'b1;
            end
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q   <= '0;
      cur_q    <= '0;
      pend_q   <= '0;
      mode_q   <= MODE_IDLE;
      st_q     <= ST_IDLE;
      idx_q    <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      skip_q   <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      live_q   <= live_d;
      cur_q    <= cur_d;
      pend_q   <= pend_d;
      mode_q   <= mode_d;
      st_q     <= st_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      skip_q   <= skip_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    tgt_q  <= tgt_d;
    hold_q <= hold_d;
    if (hw_en) begin
      head_q[hw_idx] <= item_i.docid;
    end
  end

endmodule

>>> rtl/sorted_list_union_merge_top.sv
// ----------------------------------------------------------------------------
// sorted_list_union_merge_top
// Deduplicated union of up to eight ascending document-id streams.
// ----------------------------------------------------------------------------
// Input channel: push/full queue. Words load a lane head, ask for the next
// union id, skip to a target, or carry a lane's reply to a request.
// Result channel: empty/pop queue; the oldest result sits on the ports while
// empty is low. The final result of each input word that produces results has last set.
// Words pass a two-entry input queue into a sequencer that handles one word
// at a time. A load or reply without a report only updates lane state;
// next and skip scan the lanes one per cycle while the result queue is
// not full, and each reported minimum comes from a further scan of the
// live lane heads. A skip to a target at or below the current id needs none.
// Results go through a four-entry queue; while it is full the sequencer
// waits, and the input queue fills up and raises full.
// Reset clears lane live flags, the current id, pending state and both
// queues; lanes_in_use returns to 2. Write it only while the block is idle.
// ----------------------------------------------------------------------------
`include "sorted_list_union_merge_top_macros.svh"

module sorted_list_union_merge_top import slum_pkg::*; #(
  parameter int LANES = LANES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [2:0]  lane_i,
  input  logic [31:0] lane_docid_i,
  input  logic        lane_ended_i,
  input  logic [31:0] target_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [2:0]  lane_res_o,
  output logic [31:0] docid_o,
  output logic        last_o
);

  localparam int NL = lanes_eff(LANES);

  logic [3:0] cfg_q, n_eff;
  item_t      item;
  logic       ivalid, ipop, opush, ofull, ovalid;
  logic       rep_push;
  res_t       res, ores;
  logic [$bits(res_t)-1:0] ordata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign n_eff = (cfg_q > 4'(NL)) ? 4'(NL) : cfg_q;

  slum_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .lane_i      (lane_i),
    .lane_docid_i(lane_docid_i),
    .lane_ended_i(lane_ended_i),
    .target_i    (target_i),
    .pop_i       (ipop),
    .item_o      (item),
    .valid_o     (ivalid)
  );

  slum_back #(.LANES(LANES)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .n_i    (n_eff),
    .item_i (item),
    .valid_i(ivalid),
    .pop_o  (ipop),
    .push_o (opush),
    .res_o  (res),
    .full_i (ofull)
  );

  slum_fifo #(.W($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (opush),
    .wdata_i(res),
    .full_o (ofull),
    .pop_i  (pop),
    .rdata_o(ordata),
    .valid_o(ovalid)
  );

  assign ores       = res_t'(ordata);
  assign empty      = !ovalid;
  assign kind_o     = ores.kind;
  assign lane_res_o = ores.lane;
  assign docid_o    = ores.docid;
  assign last_o     = ores.last;

  // a reported id or exhaustion always closes its word
  assign rep_push = opush && (res.kind == KIND_CUR || res.kind == KIND_END);

  `SLUM_NEVER(a_no_push_full, clk_i, rst_ni, opush && ofull)
  `SLUM_NEVER(a_no_pop_empty, clk_i, rst_ni, ipop && !ivalid)
  `SLUM_ASSERT(a_report_last, clk_i, rst_ni, rep_push |-> res.last)

endmodule
